>>> rtl/core/arfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfp_pkg
// Shared types and constants of the receive frame parser.
// ----------------------------------------------------------------------------
package arfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned OutDataW = 64;

  localparam logic [ByteW-1:0] StartByte   = 8'h7E;
  localparam logic [ByteW-1:0] ReceiveType = 8'h81;
  localparam logic [ByteW-1:0] CheckBase   = 8'hFF;
  localparam logic [WordW-1:0] HeaderBytes = 16'd4;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO_LEN  = 3'd1,
    ST_BAD_SUM   = 3'd2,
    ST_WRONG_TYP = 3'd3,
    ST_SHORT     = 3'd4
  } status_t;

  typedef struct packed {
    logic [StatusW-1:0] frame_status;
    logic [WordW-1:0]   message_length;
    logic [ByteW-1:0]   option_bits;
    logic [ByteW-1:0]   signal_strength;
    logic [WordW-1:0]   source_address;
    logic [ByteW-1:0]   data_byte;
    logic               is_end;
  } result_t;

endpackage

>>> rtl/core/arfp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfp_in_stage
// Input register for received bytes; holds one byte until the parser takes it.
// ----------------------------------------------------------------------------
module arfp_in_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [arfp_pkg::ByteW-1:0] s_axis_tdata,
  input  logic                    take,
  output logic                    byte_valid,
  output logic [arfp_pkg::ByteW-1:0] byte_data
);
  import arfp_pkg::*;

  logic             held;
  logic [ByteW-1:0] held_byte;

  assign s_axis_tready = !held || take;
  assign byte_valid    = held;
  assign byte_data     = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_axis_tready) begin
      held <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      held_byte <= s_axis_tdata;
    end
  end

endmodule

>>> rtl/core/arfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfp_parser
// Frame state machine: one byte per step, produces at most one result.
// ----------------------------------------------------------------------------
module arfp_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [arfp_pkg::ByteW-1:0] rx_byte,
  output logic                       produce,
  output arfp_pkg::result_t          result
);
  import arfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_TYPE   = 3'd3,
    PH_BODY   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_t;

  phase_t           phase, phase_next;
  logic [WordW-1:0] frame_length, frame_length_next;
  logic [WordW-1:0] bytes_seen, bytes_seen_next;
  logic [ByteW-1:0] running_sum, running_sum_next;
  logic [ByteW-1:0] frame_kind, frame_kind_next;
  logic [WordW-1:0] sender_word, sender_word_next;
  logic [ByteW-1:0] strength_byte, strength_byte_next;
  logic [ByteW-1:0] options_byte, options_byte_next;

  function automatic result_t end_item(logic [WordW-1:0] len, logic [WordW-1:0] src,
                                       logic [ByteW-1:0] rssi, logic [ByteW-1:0] opt,
                                       status_t st);
    result_t r;
    r                 = '0;
    r.is_end          = 1'b1;
    r.source_address  = src;
    r.signal_strength = rssi;
    r.option_bits     = opt;
    r.message_length  = (len > HeaderBytes) ? len - (HeaderBytes + 16'd1) : '0;
    r.frame_status    = st;
    return r;
  endfunction

  always_comb begin
    status_t st;
    st                 = ST_OK;
    phase_next         = phase;
    frame_length_next  = frame_length;
    bytes_seen_next    = bytes_seen;
    running_sum_next   = running_sum;
    frame_kind_next    = frame_kind;
    sender_word_next   = sender_word;
    strength_byte_next = strength_byte;
    options_byte_next  = options_byte;
    produce            = 1'b0;
    result             = '0;
    case (phase)
      PH_LEN_HI: begin
        frame_length_next = {rx_byte, 8'h00};
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_next = {frame_length[WordW-1:ByteW], rx_byte};
        if (frame_length_next == '0) begin
          produce    = 1'b1;
          result     = end_item(frame_length_next, sender_word, strength_byte,
                                options_byte, ST_ZERO_LEN);
          phase_next = PH_HUNT;
        end else begin
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        frame_kind_next  = rx_byte;
        running_sum_next = rx_byte;
        bytes_seen_next  = '0;
        phase_next       = (frame_length == 16'd1) ? PH_CHECK : PH_BODY;
      end
      PH_BODY: begin
        running_sum_next = running_sum + rx_byte;
        bytes_seen_next  = bytes_seen + 16'd1;
        // Length is at least one here, so length minus one cannot wrap.
        if (bytes_seen_next >= frame_length - 16'd1) begin
          phase_next = PH_CHECK;
        end
        if (bytes_seen == 16'd0) begin
          sender_word_next = {rx_byte, 8'h00};
        end else if (bytes_seen == 16'd1) begin
          sender_word_next = {sender_word[WordW-1:ByteW], rx_byte};
        end else if (bytes_seen == 16'd2) begin
          strength_byte_next = rx_byte;
        end else if (bytes_seen == 16'd3) begin
          options_byte_next = rx_byte;
        end else if (frame_kind == ReceiveType) begin
          produce          = 1'b1;
          result.data_byte = rx_byte;
        end
      end
      PH_CHECK: begin
        if (frame_length <= HeaderBytes) begin
          st = ST_SHORT;
        end else if (frame_kind != ReceiveType) begin
          st = ST_WRONG_TYP;
        end else if (CheckBase - running_sum != rx_byte) begin
          st = ST_BAD_SUM;
        end else begin
          st = ST_OK;
        end
        produce    = 1'b1;
        result     = end_item(frame_length, sender_word, strength_byte, options_byte, st);
        phase_next = PH_HUNT;
      end
      default: begin
        if (rx_byte == StartByte) begin
          frame_length_next  = '0;
          bytes_seen_next    = '0;
          running_sum_next   = '0;
          frame_kind_next    = '0;
          sender_word_next   = '0;
          strength_byte_next = '0;
          options_byte_next  = '0;
          phase_next         = PH_LEN_HI;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_length  <= '0;
      bytes_seen    <= '0;
      running_sum   <= '0;
      frame_kind    <= '0;
      sender_word   <= '0;
      strength_byte <= '0;
      options_byte  <= '0;
    end else if (step) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      bytes_seen    <= bytes_seen_next;
      running_sum   <= running_sum_next;
      frame_kind    <= frame_kind_next;
      sender_word   <= sender_word_next;
      strength_byte <= strength_byte_next;
      options_byte  <= options_byte_next;
    end
  end

  // The body counter never runs past the body of the current frame.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (bytes_seen < frame_length))
    else $error("body counter beyond frame length");

  // A payload byte only comes out of a receive-type frame past its header.
  assert property (@(posedge clk) disable iff (rst)
    (step && produce && !result.is_end) |->
      (frame_kind == ReceiveType && bytes_seen >= HeaderBytes))
    else $error("payload byte outside message body");

  // The phase register only ever holds one of the defined phases.
  assert property (@(posedge clk) disable iff (rst) phase <= PH_CHECK)
    else $error("phase register holds an unused code");

endmodule

>>> rtl/core/arfp_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfp_out_fifo
// Two-entry result buffer; the parser runs while the sink stalls until full.
// ----------------------------------------------------------------------------
module arfp_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  arfp_pkg::result_t push_data,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output arfp_pkg::result_t out_data
);
  import arfp_pkg::*;

  result_t     slot [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  count;
  logic        pop;

  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign has_room  = (count != 2'd2);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> has_room)
    else $error("result pushed into a full buffer");

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result buffer count out of range");

  // Pointers differ exactly when one entry is held.
  assert property (@(posedge clk) disable iff (rst)
    (rd_ptr != wr_ptr) == (count == 2'd1))
    else $error("result buffer pointers disagree with count");

endmodule

>>> rtl/core/api_receive_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_receive_frame_parser_unit
// Deframer for received radio-modem API frames, one serial byte per cycle while the result buffer has room.
// ----------------------------------------------------------------------------
// Received bytes enter on the s_axis channel, one byte per transaction.
// Bytes before a start byte are dropped. Message bytes past the 4-byte
// header of a receive frame leave on m_axis with tlast low; each frame ends
// with one m_axis transaction with tlast high that carries the header
// fields, the message length and the status.
// A byte taken on s_axis is held in the input register and parsed from
// there; the parser pushes its result into the result buffer, which
// offers it on m_axis.
// Throughput: one byte per cycle while the result buffer has room; the
// parser updates its frame state once per byte in a single step between
// the input register and the two-entry result buffer.
// Reset clears all frame state, the input register and the result buffer;
// the parser then hunts for a start byte.
// When the receiver stalls, the result buffer absorbs up to two results;
// once it is full the parser holds, the input register keeps one more byte
// and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module api_receive_frame_parser_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [arfp_pkg::ByteW-1:0]    s_axis_tdata,  // [7:0] rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] data_byte, [23:8] source_address, [31:24] signal_strength,
  // [39:32] option_bits, [55:40] message_length, [58:56] frame_status,
  // [63:59] zero
  output logic [arfp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast   // is_end
);
  import arfp_pkg::*;

  logic             byte_valid;
  logic [ByteW-1:0] byte_data;
  logic             has_room;
  logic             step;
  logic             produce;
  result_t          result;
  result_t          out_res;

  assign step = byte_valid && has_room;

  arfp_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .take         (step),
    .byte_valid   (byte_valid),
    .byte_data    (byte_data)
  );

  arfp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .rx_byte(byte_data),
    .produce(produce),
    .result (result)
  );

  arfp_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (step && produce),
    .push_data(result),
    .has_room (has_room),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.frame_status, out_res.message_length,
                         out_res.option_bits, out_res.signal_strength,
                         out_res.source_address, out_res.data_byte};
  assign m_axis_tlast = out_res.is_end;

endmodule
